// ===== sv/ttfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttfp_pkg
// Shared types, codes and character constants of the tagged text frame
// parser: event codes, frame delimiters and the checksum record name.
// ----------------------------------------------------------------------------
package ttfp_pkg;

   // field widths
   localparam int BYTE_W  = 8;
   localparam int EVENT_W = 4;
   localparam int FILL_W  = 6;

   // default capacities
   localparam int NAME_CAP_DEF  = 9;
   localparam int VALUE_CAP_DEF = 33;

   // default bad frame tolerance after reset
   localparam logic [BYTE_W-1:0] TOLERANCE_RST = 8'd3;

   // event codes on the result beat
   typedef enum logic [EVENT_W-1:0] {
      EV_NONE       = 4'd0,
      EV_NAME_CHAR  = 4'd1,
      EV_VALUE_CHAR = 4'd2,
      EV_NAME_END   = 4'd3,
      EV_REC_OK     = 4'd4,
      EV_REC_DROP   = 4'd5,
      EV_FRAME_GOOD = 4'd6,
      EV_FRAME_BAD  = 4'd7,
      EV_HEX_END    = 4'd8
   } event_type;

   // delimiter characters
   localparam logic [BYTE_W-1:0] CH_COLON   = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
   localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7A;
   localparam logic [BYTE_W-1:0] CASE_DIFF  = 8'h20;

   // name of the record that closes a frame
   localparam int TAG_LEN = 8;
   localparam logic [BYTE_W-1:0] CHECK_TAG [TAG_LEN] = '{
      8'h43, 8'h48, 8'h45, 8'h43, 8'h4B, 8'h53, 8'h55, 8'h4D
   };

   // ascii a-z to upper case, everything else unchanged
   function automatic logic [BYTE_W-1:0] to_upper(input logic [BYTE_W-1:0] c);
      if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
         return c - CASE_DIFF;
      end
      return c;
   endfunction

endpackage

// ===== sv/tagged_text_frame_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_text_frame_parser
// Parses a serial text frame of newline / name / tab / value records closed
// by a CHECKSUM record, one byte per beat, and gives one event per byte.
// ----------------------------------------------------------------------------
//  channel  ports                                          direction
//  req      req_valid req_ready req_in_byte                in
//  rsp      rsp_valid rsp_ready rsp_event_res rsp_char_out out
//           rsp_error_flag rsp_bad_frame_count
//  csr      csr_wr_en csr_wr_data                          in, write only
//
// One byte is taken per cycle; its event is in the result register in the next
// cycle. The parse state, running sum and fill count are updated in the same
// cycle the byte is taken, so consecutive bytes follow back to back.
// A stalled result holds and blocks the next byte only while rsp_ready is low.
// Synchronous reset returns to idle with sum, counts and error flag cleared
// and the tolerance at 3; the name store is not cleared.
// ----------------------------------------------------------------------------
module tagged_text_frame_parser
   import ttfp_pkg::*;
#(
   parameter int NAME_CAP  = NAME_CAP_DEF,
   parameter int VALUE_CAP = VALUE_CAP_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // byte input
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [BYTE_W-1:0]   req_in_byte,
   // event output
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [EVENT_W-1:0]  rsp_event_res,
   output logic [BYTE_W-1:0]   rsp_char_out,
   output logic                rsp_error_flag,
   output logic [BYTE_W-1:0]   rsp_bad_frame_count,
   // tolerance register
   input  logic                csr_wr_en,
   input  logic [BYTE_W-1:0]   csr_wr_data
);

   localparam int NAME_IDX_W = (NAME_CAP > 1) ? $clog2(NAME_CAP) : 1;
   localparam logic [FILL_W-1:0] NAME_CAP_F  = FILL_W'(NAME_CAP);
   localparam logic [FILL_W-1:0] VALUE_CAP_F = FILL_W'(VALUE_CAP);
   localparam logic [FILL_W-1:0] TAG_LEN_F   = FILL_W'(TAG_LEN);
   localparam logic [BYTE_W-1:0] COUNT_MAX   = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BEGIN,
      ST_NAME,
      ST_VALUE,
      ST_CHECK,
      ST_HEX
   } state_type;

   // registers
   state_type           state_ff, state_in;
   logic [BYTE_W-1:0]   sum_ff, sum_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [BYTE_W-1:0]   bad_ff, bad_in;
   logic                error_ff, error_in;
   logic [BYTE_W-1:0]   tol_ff;
   logic                rsp_valid_ff;
   event_type           event_ff, event_in;
   logic [BYTE_W-1:0]   char_ff, char_in;
   logic [BYTE_W-1:0]   name_store_ff [NAME_CAP];

   // combinational helpers
   logic                accept;
   logic [BYTE_W-1:0]   uc;
   state_type           state_w;
   logic [BYTE_W-1:0]   sum_add;
   logic                tag_match;
   logic                name_we;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // name compare against the closing record tag
   always_comb begin
      tag_match = (fill_ff == TAG_LEN_F);
      for (int i = 0; i < TAG_LEN; i++) begin
         if (name_store_ff[i] != CHECK_TAG[i]) begin
            tag_match = 1'b0;
         end
      end
   end

   // next state for one byte
   always_comb begin
      uc       = to_upper(req_in_byte);
      state_w  = (req_in_byte == CH_COLON && state_ff != ST_CHECK) ? ST_HEX : state_ff;
      sum_add  = sum_ff + req_in_byte;
      sum_in   = (state_w != ST_HEX) ? sum_add : sum_ff;
      state_in = state_w;
      fill_in  = fill_ff;
      bad_in   = bad_ff;
      error_in = error_ff;
      event_in = EV_NONE;
      char_in  = '0;
      name_we  = 1'b0;
      unique case (state_w)
         ST_IDLE: begin
            if (uc == CH_NEWLINE) begin
               state_in = ST_BEGIN;
            end
         end
         ST_BEGIN: begin
            fill_in  = FILL_W'(1);
            state_in = ST_NAME;
            event_in = EV_NAME_CHAR;
            char_in  = uc;
         end
         ST_NAME: begin
            if (uc == CH_TAB) begin
               event_in = EV_NAME_END;
               if (fill_ff < NAME_CAP_F && tag_match) begin
                  state_in = ST_CHECK;
               end else begin
                  fill_in  = '0;
                  state_in = ST_VALUE;
               end
            end else begin
               if (fill_ff < NAME_CAP_F) begin
                  name_we = 1'b1;
                  fill_in = fill_ff + FILL_W'(1);
               end
               event_in = EV_NAME_CHAR;
               char_in  = uc;
            end
         end
         ST_VALUE: begin
            if (uc == CH_NEWLINE) begin
               event_in = (fill_ff < VALUE_CAP_F) ? EV_REC_OK : EV_REC_DROP;
               state_in = ST_BEGIN;
            end else if (uc != CH_CR) begin
               if (fill_ff < VALUE_CAP_F) begin
                  fill_in = fill_ff + FILL_W'(1);
               end
               event_in = EV_VALUE_CHAR;
               char_in  = uc;
            end
         end
         ST_CHECK: begin
            if (sum_add == '0) begin
               bad_in   = '0;
               event_in = EV_FRAME_GOOD;
            end else begin
               if (bad_ff != COUNT_MAX) begin
                  bad_in = bad_ff + BYTE_W'(1);
               end
               event_in = EV_FRAME_BAD;
            end
            error_in = (bad_in >= tol_ff);
            sum_in   = '0;
            state_in = ST_IDLE;
         end
         ST_HEX: begin
            if (uc == CH_NEWLINE) begin
               sum_in   = '0;
               state_in = ST_IDLE;
               event_in = EV_HEX_END;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // parse state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         fill_ff      <= '0;
         bad_ff       <= '0;
         error_ff     <= 1'b0;
         tol_ff       <= TOLERANCE_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tol_ff <= csr_wr_data;
         end
         if (accept) begin
            state_ff     <= state_in;
            sum_ff       <= sum_in;
            fill_ff      <= fill_in;
            bad_ff       <= bad_in;
            error_ff     <= error_in;
            event_ff     <= event_in;
            char_ff      <= char_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // name store, first name character goes to entry zero
   always_ff @(posedge clock) begin
      if (accept && state_w == ST_BEGIN) begin
         name_store_ff[0] <= uc;
      end else if (accept && name_we) begin
         name_store_ff[fill_ff[NAME_IDX_W-1:0]] <= uc;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_res       = event_ff;
   assign rsp_char_out        = char_ff;
   assign rsp_error_flag      = error_ff;
   assign rsp_bad_frame_count = bad_ff;

   // a taken byte always produces a result beat
   a_accept_gives_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted byte gave no result beat");

   // character only carried on name and value character events
   a_char_only_on_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != EV_NAME_CHAR && rsp_event_res != EV_VALUE_CHAR
      |-> rsp_char_out == '0)
      else $error("character on a non-character event");

   // good frame clears the bad frame count
   a_good_clears_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_FRAME_GOOD |-> rsp_bad_frame_count == '0)
      else $error("bad frame count not cleared on good frame");

   // error flag moves only at a frame end
   a_error_at_frame_end: assert property (@(posedge clock) disable iff (reset)
      !$stable(error_ff) && !$past(reset) |-> $past(accept && state_w == ST_CHECK))
      else $error("error flag changed outside a frame end");

endmodule

// ===== tb/tagged_text_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_text_frame_checker
// Watches the byte, event and tolerance ports of the text frame parser,
// predicts one event per accepted byte from its own copy of the parse state
// and compares every accepted event beat field by field, oldest first.
// ----------------------------------------------------------------------------
module tagged_text_frame_checker
   import ttfp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [BYTE_W-1:0]   req_in_byte,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [EVENT_W-1:0]  rsp_event_res,
   input  logic [BYTE_W-1:0]   rsp_char_out,
   input  logic                rsp_error_flag,
   input  logic [BYTE_W-1:0]   rsp_bad_frame_count,
   input  logic                csr_wr_en,
   input  logic [BYTE_W-1:0]   csr_wr_data,
   output int                  fail_count,
   output int                  expected_left,
   output int                  events_checked
);

   localparam int NAME_CAP  = NAME_CAP_DEF;
   localparam int VALUE_CAP = VALUE_CAP_DEF;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_BEGIN,
      PH_NAME,
      PH_VALUE,
      PH_CHECK,
      PH_HEX
   } parse_phase_type;

   typedef struct {
      event_type         ev;
      logic [BYTE_W-1:0] ch;
      logic              err;
      logic [BYTE_W-1:0] bad;
   } frame_event_type;

   // predicted parser state
   parse_phase_type   phase;
   logic [BYTE_W-1:0] frame_sum;
   logic [BYTE_W-1:0] name_buf [NAME_CAP];
   int                fill;
   logic [BYTE_W-1:0] bad_run;
   logic              err_flag;
   logic [BYTE_W-1:0] tolerance;

   frame_event_type pending_events [$];

   initial begin
      fail_count     = 0;
      expected_left  = 0;
      events_checked = 0;
   end

   // one byte through the predicted parser, returns its event
   function automatic frame_event_type parse_byte(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] c;
      frame_event_type   r;
      logic              tag_hit;
      r.ev = EV_NONE;
      r.ch = '0;
      if (b == CH_COLON && phase != PH_CHECK) begin
         phase = PH_HEX;
      end
      if (phase != PH_HEX) begin
         frame_sum = frame_sum + b;
      end
      c = (b >= CH_LOWER_A && b <= CH_LOWER_Z) ? b - CASE_DIFF : b;
      case (phase)
         PH_IDLE: begin
            if (c == CH_NEWLINE) begin
               phase = PH_BEGIN;
            end
         end
         // first byte after a newline is a name character unless it is a colon
         PH_BEGIN: begin
            name_buf[0] = c;
            fill = 1;
            phase = PH_NAME;
            r.ev = EV_NAME_CHAR;
            r.ch = c;
         end
         PH_NAME: begin
            if (c == CH_TAB) begin
               r.ev = EV_NAME_END;
               tag_hit = (fill == TAG_LEN);
               for (int i = 0; i < TAG_LEN; i++) begin
                  if (name_buf[i] != CHECK_TAG[i]) begin
                     tag_hit = 1'b0;
                  end
               end
               if (tag_hit && fill < NAME_CAP) begin
                  phase = PH_CHECK;
               end else begin
                  fill = 0;
                  phase = PH_VALUE;
               end
            end else begin
               // characters past the name capacity are dropped
               if (fill < NAME_CAP) begin
                  name_buf[fill] = c;
                  fill++;
               end
               r.ev = EV_NAME_CHAR;
               r.ch = c;
            end
         end
         PH_VALUE: begin
            if (c == CH_NEWLINE) begin
               r.ev = (fill < VALUE_CAP) ? EV_REC_OK : EV_REC_DROP;
               phase = PH_BEGIN;
            end else if (c != CH_CR) begin
               if (fill < VALUE_CAP) begin
                  fill++;
               end
               r.ev = EV_VALUE_CHAR;
               r.ch = c;
            end
         end
         // byte after the checksum tab closes the frame
         PH_CHECK: begin
            if (frame_sum == '0) begin
               bad_run = '0;
               r.ev = EV_FRAME_GOOD;
            end else begin
               if (bad_run != 8'hFF) begin
                  bad_run++;
               end
               r.ev = EV_FRAME_BAD;
            end
            err_flag = (bad_run >= tolerance);
            frame_sum = '0;
            phase = PH_IDLE;
         end
         PH_HEX: begin
            if (c == CH_NEWLINE) begin
               frame_sum = '0;
               phase = PH_IDLE;
               r.ev = EV_HEX_END;
            end
         end
         default: phase = PH_IDLE;
      endcase
      r.err = err_flag;
      r.bad = bad_run;
      return r;
   endfunction

   function automatic int field_bad(input string what, input logic [BYTE_W-1:0] want,
                                    input logic [BYTE_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
         return 1;
      end
      return 0;
   endfunction

   // compare event beats, then queue the prediction for a new byte beat
   always @(posedge clock) begin
      frame_event_type want;
      if (reset) begin
         phase     = PH_IDLE;
         frame_sum = '0;
         fill      = 0;
         bad_run   = '0;
         err_flag  = 1'b0;
         tolerance = TOLERANCE_RST;
         for (int i = 0; i < NAME_CAP; i++) begin
            name_buf[i] = '0;
         end
         pending_events.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_events.size() == 0) begin
               $display("%0t: event beat with nothing expected, got event %0d",
                        $time, rsp_event_res);
               fail_count++;
            end else begin
               want = pending_events.pop_front();
               fail_count += field_bad("event", BYTE_W'(want.ev), BYTE_W'(rsp_event_res))
                           + field_bad("char", want.ch, rsp_char_out)
                           + field_bad("error flag", BYTE_W'(want.err),
                                       BYTE_W'(rsp_error_flag))
                           + field_bad("bad frame count", want.bad, rsp_bad_frame_count);
               events_checked++;
            end
         end
         if (req_valid && req_ready) begin
            pending_events.push_back(parse_byte(req_in_byte));
         end
         if (csr_wr_en) begin
            tolerance = csr_wr_data;
         end
      end
      expected_left <= pending_events.size();
   end

endmodule

// ===== tb/tagged_text_frame_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_text_frame_parser_tb
// Drives byte streams into the text frame parser: a short directed opening,
// then well-formed frames with random content mixed with hex records, noise
// and cut-off records, under several bad frame tolerances. Both channels
// idle at random; the event checker beside the block judges every beat.
// ----------------------------------------------------------------------------
module tagged_text_frame_parser_tb;
   import ttfp_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 300;

   // idle bytes, hex mode, record start oddities, value cr, colon in a name
   localparam logic [BYTE_W-1:0] OPENING_BYTES [16] = '{
      8'h00, 8'hFF, 8'h7A, CH_COLON, 8'h71, CH_NEWLINE, CH_NEWLINE, CH_TAB,
      8'h61, CH_TAB, 8'h6D, CH_CR, CH_NEWLINE, CH_NEWLINE, CH_COLON, CH_NEWLINE
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_in_byte = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [EVENT_W-1:0]  rsp_event_res;
   logic [BYTE_W-1:0]   rsp_char_out;
   logic                rsp_error_flag;
   logic [BYTE_W-1:0]   rsp_bad_frame_count;
   logic                csr_wr_en = 1'b0;
   logic [BYTE_W-1:0]   csr_wr_data = '0;

   int                  fail_count;
   int                  expected_left;
   int                  events_checked;
   int                  cycle_count = 0;
   int                  bytes_sent = 0;
   int                  frames_sent = 0;
   logic [BYTE_W-1:0]   tx_sum = '0;
   bit                  quiet_tail = 1'b0;
   bit                  hold_request = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   tagged_text_frame_parser #(
      .NAME_CAP  (NAME_CAP_DEF),
      .VALUE_CAP (VALUE_CAP_DEF)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_in_byte         (req_in_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_event_res       (rsp_event_res),
      .rsp_char_out        (rsp_char_out),
      .rsp_error_flag      (rsp_error_flag),
      .rsp_bad_frame_count (rsp_bad_frame_count),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   tagged_text_frame_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_in_byte         (req_in_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_event_res       (rsp_event_res),
      .rsp_char_out        (rsp_char_out),
      .rsp_error_flag      (rsp_error_flag),
      .rsp_bad_frame_count (rsp_bad_frame_count),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .fail_count          (fail_count),
      .expected_left       (expected_left),
      .events_checked      (events_checked)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tagged_text_frame_parser_tb failed");
         $finish;
      end
   end

   // event side: random stall bursts, one long hold-off on request
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   // offer one byte beat, hold it until taken, then maybe go idle a while
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      tx_sum = tx_sum + b;
      bytes_sent++;
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // back to idle from any parser state, sum cleared
   task automatic resync();
      send_byte(CH_COLON);
      send_byte(CH_COLON);
      send_byte(CH_NEWLINE);
      tx_sum = '0;
   endtask

   // newline, name, tab, value; the next newline closes it
   task automatic send_record();
      int                len;
      int                vlen;
      bit                near;
      logic [BYTE_W-1:0] ch;
      near = 1'b0;
      send_byte(CH_NEWLINE);
      case ($urandom_range(0, 9))
         0: len = $urandom_range(NAME_CAP_DEF, NAME_CAP_DEF + 3);
         1: begin
            near = 1'b1;
            len = ($urandom_range(0, 1) != 0) ? TAG_LEN - 1 : TAG_LEN + 1;
         end
         default: len = $urandom_range(1, 8);
      endcase
      for (int i = 0; i < len; i++) begin
         if (near) begin
            ch = (i < TAG_LEN) ? CHECK_TAG[i] : 8'h58;
         end else begin
            // a tab is only a name character right after the newline
            do ch = BYTE_W'($urandom_range(0, 255));
            while (ch == CH_COLON || (i != 0 && ch == CH_TAB));
         end
         send_byte(ch);
      end
      send_byte(CH_TAB);
      vlen = ($urandom_range(0, 9) == 0) ? $urandom_range(VALUE_CAP_DEF - 2, VALUE_CAP_DEF + 5)
                                         : $urandom_range(0, 6);
      for (int i = 0; i < vlen; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            ch = CH_CR;
         end else begin
            do ch = BYTE_W'($urandom_range(0, 255));
            while (ch == CH_NEWLINE || ch == CH_COLON);
         end
         send_byte(ch);
      end
   endtask

   // checksum record in random case and the byte that closes the frame
   task automatic send_closing(input bit make_good, input bit colon_close);
      logic [BYTE_W-1:0] ch;
      logic [BYTE_W-1:0] right;
      send_byte(CH_NEWLINE);
      for (int i = 0; i < TAG_LEN; i++) begin
         ch = CHECK_TAG[i];
         if ($urandom_range(0, 1) != 0) begin
            ch = ch + CASE_DIFF;
         end
         send_byte(ch);
      end
      send_byte(CH_TAB);
      right = 8'h00 - tx_sum;
      if (make_good) begin
         ch = right;
      end else if (colon_close) begin
         ch = CH_COLON;
      end else begin
         ch = BYTE_W'($urandom_range(0, 255));
         if (ch == right) begin
            ch = ch + 8'd1;
         end
      end
      send_byte(ch);
      tx_sum = '0;
      frames_sent++;
   endtask

   // mostly well-formed frames, the rest hex records, noise and cut records
   task automatic random_traffic(input int n_bytes);
      int                target;
      int                pick;
      logic [BYTE_W-1:0] ch;
      target = bytes_sent + n_bytes;
      while (bytes_sent < target) begin
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            if ($urandom_range(0, 4) == 0) begin
               repeat ($urandom_range(1, 3)) begin
                  do ch = BYTE_W'($urandom_range(0, 255));
                  while (ch == CH_NEWLINE || ch == CH_COLON);
                  send_byte(ch);
               end
            end
            repeat ($urandom_range(0, 3)) send_record();
            send_closing(pick < 11, $urandom_range(0, 3) == 0);
         end else if (pick < 16) begin
            send_byte(CH_COLON);
            repeat ($urandom_range(0, 8)) begin
               do ch = BYTE_W'($urandom_range(0, 255));
               while (ch == CH_NEWLINE);
               send_byte(ch);
            end
            send_byte(CH_NEWLINE);
            tx_sum = '0;
         end else if (pick < 18) begin
            repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom_range(0, 255)));
            resync();
         end else begin
            send_record();
            resync();
         end
      end
   endtask

   // stop offering and wait for every predicted event to come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_left != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [BYTE_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin : stimulus
      int mid_tol;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed opening under the reset tolerance, closed by a colon
      foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i]);
      send_closing(1'b0, 1'b1);
      random_traffic(150);
      wait_drained();

      // tolerance zero: flag rises at the next frame end, good or bad
      write_tolerance(8'd0);
      random_traffic(250);
      wait_drained();

      // a run of bad frames past the tolerance, then a good one
      write_tolerance(8'd20);
      repeat (25) send_closing(1'b0, 1'b0);
      send_closing(1'b1, 1'b0);
      wait_drained();

      mid_tol = $urandom_range(1, 6);
      write_tolerance(mid_tol[BYTE_W-1:0]);
      random_traffic(250);
      wait_drained();

      // long event hold-off while bytes are offered, then a gap-free tail
      write_tolerance(8'd2);
      hold_request = 1'b1;
      random_traffic(200);
      quiet_tail = 1'b1;
      random_traffic(100);
      wait_drained();

      $display("%0d bytes sent, %0d closing records, %0d events checked",
               bytes_sent, frames_sent, events_checked);
      $display("tolerances 3, 0, 20, %0d and 2; a bad frame run past the tolerance",
               mid_tol);
      if (fail_count == 0 && expected_left == 0) begin
         $display("tagged_text_frame_parser_tb passed");
      end else begin
         $display("tagged_text_frame_parser_tb failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/ttfp_pkg.sv
sv/tagged_text_frame_parser.sv
tb/tagged_text_frame_checker.sv
tb/tagged_text_frame_parser_tb.sv
